// ===== rtl/core/alucc_pkg.sv =====
// Shared types and constants for the ALU with condition codes.
package alucc_pkg;

  typedef enum logic [4:0] {
    CMD_ADD  = 5'd0,  CMD_SUB  = 5'd1,  CMD_AND  = 5'd2,  CMD_XOR  = 5'd3,
    CMD_OR   = 5'd4,  CMD_SHL  = 5'd5,  CMD_SHR  = 5'd6,  CMD_SAR  = 5'd7,
    CMD_MUL  = 5'd8,  CMD_DIV  = 5'd9,  CMD_REM  = 5'd10, CMD_MOD  = 5'd11,
    CMD_MIN  = 5'd12, CMD_MAX  = 5'd13, CMD_PASS = 5'd14, CMD_ADDR = 5'd15,
    CMD_PUSH = 5'd16, CMD_POP  = 5'd17, CMD_INC  = 5'd18, CMD_DEC  = 5'd19,
    CMD_CMP  = 5'd20, CMD_TEST = 5'd21, CMD_COND = 5'd22
  } cmd_t;

  typedef enum logic [2:0] {
    SEL_ALWAYS = 3'd0, SEL_LE = 3'd1, SEL_LT = 3'd2, SEL_EQ = 3'd3,
    SEL_NE = 3'd4, SEL_GE = 3'd5, SEL_GT = 3'd6
  } sel_t;

  typedef struct packed {
    logic zf;
    logic sf;
    logic of;
  } flags_t;

  // Done status from the iterative unit to the top level.
  typedef struct packed {
    logic done;
    logic div_err;
    logic setcc;
    logic ovf;
  } iu_stat_t;

  localparam int unsigned STACK_STEP = 8;

endpackage

// ===== rtl/core/alucc_iter.sv =====
// Iterative shift-add multiplier and restoring divider sharing one adder.
module alucc_iter #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  is_mul,
  input  logic [4:0]            cmd,
  input  logic [DATA_WIDTH-1:0] opb,
  input  logic [DATA_WIDTH-1:0] opa,
  output logic [DATA_WIDTH-1:0] res,
  output alucc_pkg::iu_stat_t   stat
);
  localparam int CW = $clog2(DATA_WIDTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001, S_RUN = 3'b010, S_FIN = 3'b100
  } st_t;

  st_t                 st_r, st_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [DATA_WIDTH-1:0] acc_r, acc_nxt;   // product or partial remainder
  logic [DATA_WIDTH-1:0] q_r, q_nxt;       // multiplier or dividend/quotient
  logic [DATA_WIDTH-1:0] d_r, d_nxt;       // multiplicand or divisor
  logic                sb_r, sb_nxt, sa_r, sa_nxt, mul_r, mul_nxt;
  logic [4:0]          cmd_r, cmd_nxt;
  logic [DATA_WIDTH-1:0] res_r, res_nxt;
  alucc_pkg::iu_stat_t stat_r, stat_nxt;

  logic [DATA_WIDTH:0]   sum;
  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH-1:0] mb, ma, rem_s;
  logic                  sb, sa;

  assign sb = opb[DATA_WIDTH-1];
  assign sa = opa[DATA_WIDTH-1];
  assign mb = sb ? (~opb + 1'b1) : opb;
  assign ma = sa ? (~opa + 1'b1) : opa;

  // Shared adder: multiply adds, divide subtracts.
  always_comb begin
    trial = {acc_r, q_r[DATA_WIDTH-1]};
    if (mul_r) begin
      sum = {1'b0, (acc_r << 1)} + {1'b0, (q_r[DATA_WIDTH-1] ? d_r : '0)};
    end else begin
      sum = trial - {1'b0, d_r};
    end
  end

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; acc_nxt = acc_r; q_nxt = q_r; d_nxt = d_r;
    sb_nxt = sb_r; sa_nxt = sa_r; mul_nxt = mul_r; cmd_nxt = cmd_r;
    res_nxt = res_r; stat_nxt = stat_r; stat_nxt.done = 1'b0;
    rem_s = sb_r ? (~acc_r + 1'b1) : acc_r;
    unique case (st_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt = cmd; mul_nxt = is_mul; sb_nxt = sb; sa_nxt = sa;
          acc_nxt = '0; cnt_nxt = CW'(DATA_WIDTH);
          if (is_mul) begin
            q_nxt = opa; d_nxt = opb; st_nxt = S_RUN;
          end else if (opa == '0) begin
            res_nxt = '0;
            stat_nxt = '{done: 1'b1, div_err: 1'b1, setcc: 1'b0, ovf: 1'b0};
          end else begin
            q_nxt = mb; d_nxt = ma; st_nxt = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (mul_r) begin
          acc_nxt = sum[DATA_WIDTH-1:0];
        end else if (!sum[DATA_WIDTH]) begin
          acc_nxt = sum[DATA_WIDTH-1:0];
        end else begin
          acc_nxt = trial[DATA_WIDTH-1:0];
        end
        q_nxt = {q_r[DATA_WIDTH-2:0], ~mul_r & ~sum[DATA_WIDTH]};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) st_nxt = S_FIN;
      end
      S_FIN: begin
        if (mul_r) begin
          res_nxt = acc_r;
        end else if (cmd_r == alucc_pkg::CMD_DIV) begin
          res_nxt = (sb_r != sa_r) ? (~q_r + 1'b1) : q_r;
        end else if (cmd_r == alucc_pkg::CMD_MOD && sb_r != sa_r) begin
          res_nxt = ~rem_s + 1'b1;
        end else begin
          res_nxt = rem_s;
        end
        stat_nxt = '{done: 1'b1, div_err: 1'b0, setcc: 1'b1, ovf: 1'b0};
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      stat_r <= '0;
    end else begin
      st_r <= st_nxt;
      stat_r <= stat_nxt;
    end
    cnt_r <= cnt_nxt; acc_r <= acc_nxt; q_r <= q_nxt; d_r <= d_nxt;
    sb_r <= sb_nxt; sa_r <= sa_nxt; mul_r <= mul_nxt; cmd_r <= cmd_nxt;
    res_r <= res_nxt;
  end

  assign res  = res_r;
  assign stat = stat_r;
endmodule

// ===== rtl/core/alu_with_condition_codes.sv =====
// ALU with zero/sign/overflow condition codes: simple ops, iterative mul/div.
// Each request is taken when the block is idle. Simple operations deliver their result
// register in the cycle after acceptance; mul, div, rem and mod run on a shared
// one-bit-per-cycle shift/add-subtract unit, then load the output register (a zero
// divisor skips the iteration). The input is not taken again until the output
// register has been handed off. cond_true reflects the flags held before the request.
module alu_with_condition_codes #(
  parameter int DATA_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  in_command,
  input  logic signed [63:0] in_operand_b,
  input  logic signed [63:0] in_operand_a,
  input  logic [2:0]  in_cond_select,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [63:0] out_result,
  output logic        out_cond_true,
  output logic        out_divide_error
);
  localparam int DW = DATA_WIDTH;

  typedef enum logic [2:0] {
    T_IDLE = 3'b001, T_BUSY = 3'b010, T_OUT = 3'b100
  } tst_t;

  tst_t               st_r, st_nxt;
  alucc_pkg::flags_t  fl_r, fl_nxt;
  logic [DW-1:0]      res_r, res_nxt;
  logic               cond_r, cond_nxt, derr_r, derr_nxt;
  logic               accept, is_mul, is_div, lt, cond;
  logic [DW-1:0]      b, a, r, bsh;
  logic [DW:0]        ar_sum;
  logic [5:0]         amt;
  logic               setcc, ovf, big;
  logic               iu_start;
  logic [DW-1:0]      iu_res;
  alucc_pkg::iu_stat_t iu_stat;
  alucc_pkg::cmd_t    cmd;

  assign accept = in_valid && !in_stall;
  assign in_stall = (st_r != T_IDLE);
  assign b = in_operand_b[DW-1:0];
  assign a = in_operand_a[DW-1:0];
  assign amt = in_operand_a[5:0];
  assign big = ({26'd0, amt} >= 32'(DW));
  assign cmd = alucc_pkg::cmd_t'(in_command);
  assign is_mul = (cmd == alucc_pkg::CMD_MUL);
  assign is_div = (cmd == alucc_pkg::CMD_DIV) || (cmd == alucc_pkg::CMD_REM) ||
                  (cmd == alucc_pkg::CMD_MOD);
  assign iu_start = accept && (is_mul || is_div);

  assign lt = fl_r.sf ^ fl_r.of;
  always_comb begin
    case (in_cond_select)
      alucc_pkg::SEL_ALWAYS: cond = 1'b1;
      alucc_pkg::SEL_LE:     cond = lt | fl_r.zf;
      alucc_pkg::SEL_LT:     cond = lt;
      alucc_pkg::SEL_EQ:     cond = fl_r.zf;
      alucc_pkg::SEL_NE:     cond = !fl_r.zf;
      alucc_pkg::SEL_GE:     cond = !lt;
      alucc_pkg::SEL_GT:     cond = !lt && !fl_r.zf;
      default:               cond = 1'b0;
    endcase
  end

  // Single adder serves add, sub, cmp, addr, push, pop, inc, dec, min, max.
  logic [DW-1:0] x, y;
  logic          sub;
  always_comb begin
    x = b; y = a; sub = 1'b0;
    case (cmd)
      alucc_pkg::CMD_SUB, alucc_pkg::CMD_CMP,
      alucc_pkg::CMD_MIN, alucc_pkg::CMD_MAX: sub = 1'b1;
      alucc_pkg::CMD_PUSH: begin y = DW'(alucc_pkg::STACK_STEP); sub = 1'b1; end
      alucc_pkg::CMD_POP:  y = DW'(alucc_pkg::STACK_STEP);
      alucc_pkg::CMD_INC:  begin x = a; y = DW'(1); end
      alucc_pkg::CMD_DEC:  begin x = a; y = DW'(1); sub = 1'b1; end
      default: ;
    endcase
    ar_sum = {1'b0, x} + {1'b0, (sub ? ~y : y)} + {{DW{1'b0}}, sub};
  end

  logic blt;
  assign blt = (b[DW-1] != a[DW-1]) ? b[DW-1] : ar_sum[DW-1];

  always_comb begin
    bsh = '0;
    if (cmd == alucc_pkg::CMD_SAR) bsh = big ? {DW{b[DW-1]}} : DW'($signed(b) >>> amt);
    else if (cmd == alucc_pkg::CMD_SHL) bsh = big ? '0 : (b << amt);
    else bsh = big ? '0 : (b >> amt);
  end

  always_comb begin
    r = '0; setcc = 1'b1; ovf = 1'b0;
    case (cmd)
      alucc_pkg::CMD_ADD: begin
        r = ar_sum[DW-1:0];
        ovf = (b[DW-1] == a[DW-1]) && (r[DW-1] != b[DW-1]);
      end
      alucc_pkg::CMD_SUB, alucc_pkg::CMD_CMP: begin
        r = ar_sum[DW-1:0];
        ovf = (b[DW-1] != a[DW-1]) && (r[DW-1] != b[DW-1]);
      end
      alucc_pkg::CMD_AND, alucc_pkg::CMD_TEST: r = b & a;
      alucc_pkg::CMD_XOR: r = b ^ a;
      alucc_pkg::CMD_OR:  r = b | a;
      alucc_pkg::CMD_SHL, alucc_pkg::CMD_SHR, alucc_pkg::CMD_SAR: r = bsh;
      alucc_pkg::CMD_MIN: r = blt ? b : a;
      alucc_pkg::CMD_MAX: r = (blt || b == a) ? a : b;
      alucc_pkg::CMD_INC: begin
        r = ar_sum[DW-1:0];
        ovf = (a == {1'b0, {(DW-1){1'b1}}});
      end
      alucc_pkg::CMD_DEC: begin
        r = ar_sum[DW-1:0];
        ovf = (a == {1'b1, {(DW-1){1'b0}}});
      end
      alucc_pkg::CMD_PASS: begin r = a; setcc = 1'b0; end
      alucc_pkg::CMD_ADDR, alucc_pkg::CMD_PUSH, alucc_pkg::CMD_POP: begin
        r = ar_sum[DW-1:0]; setcc = 1'b0;
      end
      default: setcc = 1'b0;
    endcase
  end

  alucc_iter #(.DATA_WIDTH(DW)) u_iter (
    .clk(clk), .rst_n(rst_n), .start(iu_start), .is_mul(is_mul), .cmd(in_command),
    .opb(b), .opa(a), .res(iu_res), .stat(iu_stat)
  );

  always_comb begin
    st_nxt = st_r; fl_nxt = fl_r; res_nxt = res_r; cond_nxt = cond_r; derr_nxt = derr_r;
    unique case (st_r)
      T_IDLE: begin
        if (accept) begin
          cond_nxt = cond;
          derr_nxt = 1'b0;
          if (is_mul || is_div) begin
            st_nxt = T_BUSY;
          end else begin
            res_nxt = r;
            if (setcc) fl_nxt = '{zf: (r == '0), sf: r[DW-1], of: ovf};
            st_nxt = T_OUT;
          end
        end
      end
      T_BUSY: begin
        if (iu_stat.done) begin
          res_nxt = iu_res;
          derr_nxt = iu_stat.div_err;
          if (iu_stat.setcc) fl_nxt = '{zf: (iu_res == '0), sf: iu_res[DW-1], of: 1'b0};
          st_nxt = T_OUT;
        end
      end
      T_OUT: if (!out_stall) st_nxt = T_IDLE;
      default: st_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= T_IDLE;
      fl_r <= '0;
    end else begin
      st_r <= st_nxt;
      fl_r <= fl_nxt;
    end
    res_r <= res_nxt; cond_r <= cond_nxt; derr_r <= derr_nxt;
  end

  assign out_valid = (st_r == T_OUT);
  assign out_result = 64'($signed(res_r));
  assign out_cond_true = cond_r;
  assign out_divide_error = derr_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_error |-> out_result == 64'd0)
    else $error("divide error with nonzero result");
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == T_BUSY |-> in_stall && !out_valid)
    else $error("busy state not stalled");
  a_err_flags: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == T_BUSY && iu_stat.done && iu_stat.div_err |=> $stable(fl_r))
    else $error("flags changed on divide error");
endmodule
